// ----- hw/rtl/idr_pkg.sv -----
// Package for the interrupt distributor register file.
// Types, sizes and command encoding shared by all idr_* modules.
// No dependencies.
`timescale 1ns / 1ps
package idr_pkg;

	localparam int NUM_INTERRUPTS     = 128;
	localparam int PRIVATE_INTERRUPTS = 32;
	localparam int NUM_CORES          = 4;

	localparam int SHARED_INTS     = NUM_INTERRUPTS - PRIVATE_INTERRUPTS;
	localparam int SHARED_WORDS    = SHARED_INTS / 32;
	localparam int PRIO_PER_WORD   = 4;
	localparam int PRIV_PRIO_WORDS = PRIVATE_INTERRUPTS / PRIO_PER_WORD;
	localparam int PRIO_WORDS      = NUM_INTERRUPTS / PRIO_PER_WORD;
	localparam int PRIO_MEM_WORDS  = NUM_CORES * PRIV_PRIO_WORDS + PRIO_WORDS - PRIV_PRIO_WORDS;

	localparam int CORE_AW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int SW_AW    = (SHARED_WORDS > 1) ? $clog2(SHARED_WORDS) : 1;
	localparam int PRIO_AW  = $clog2(PRIO_MEM_WORDS);
	localparam int ROUTE_AW = $clog2(SHARED_INTS);

	localparam int Q_DEPTH  = 2;
	localparam int CTRL_W   = 7;
	localparam int ROUTE_W  = 5;

	typedef enum logic [2:0] {
		KIND_CONTROL   = 3'd0,
		KIND_SET_EN    = 3'd1,
		KIND_CLR_EN    = 3'd2,
		KIND_GROUP     = 3'd3,
		KIND_GROUP_MOD = 3'd4,
		KIND_PRIORITY  = 3'd5,
		KIND_ROUTE     = 3'd6,
		KIND_WAKE      = 3'd7
	} kind_t;

	// Decoded access handed from the front end to the back end
	typedef struct packed {
		logic                wr;
		kind_t               kind;
		logic                err;
		logic                priv;
		logic [CORE_AW-1:0]  core_idx;
		logic [SW_AW-1:0]    sh_idx;
		logic [PRIO_AW-1:0]  prio_addr;
		logic [ROUTE_AW-1:0] route_idx;
		logic [31:0]         data;
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_ZERO  = 2'd0,
		SEL_FLOP  = 2'd1,
		SEL_PRIO  = 2'd2,
		SEL_ROUTE = 2'd3
	} rd_sel_t;

endpackage

// ----- hw/rtl/idr_if.sv -----
// Request and response channel interfaces of the register file.
// No dependencies.
`timescale 1ns / 1ps
interface idr_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  reg_kind;
	logic [1:0]  core_select;
	logic [6:0]  word_index;
	logic [31:0] write_data;

	modport source (output valid, opcode, reg_kind, core_select, word_index, write_data,
		input ready);
	modport sink (input valid, opcode, reg_kind, core_select, word_index, write_data,
		output ready);
endinterface

interface idr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        access_error;

	modport source (output valid, read_data, access_error, input ready);
	modport sink (input valid, read_data, access_error, output ready);
endinterface

// ----- hw/rtl/interrupt_distributor_registers_core.sv -----
// Interrupt distributor register file, top level.
// A request passes through the queue to the back end's output register. Throughput:
// one access per cycle while results are taken; a two-entry queue parts the decode
// front end from the back end, whose output register is the only pacing element.
// Reset: asynchronous; clears flop registers and the valid bits that make the
// priority and route memories read as zero; no clearing pass is needed.
// Depends on idr_pkg, idr_if, idr_front, idr_queue, idr_back.
`timescale 1ns / 1ps
module interrupt_distributor_registers_core (
	input  logic      clk,
	input  logic      arst_n,
	idr_req_if.sink   req,
	idr_rsp_if.source rsp
);

	idr_pkg::cmd_t dec_cmd;
	idr_pkg::cmd_t head_cmd;
	logic          q_full;
	logic          q_not_empty;
	logic          q_pop;
	logic          q_push;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	idr_front u_front (
		.opcode      (req.opcode),
		.reg_kind    (req.reg_kind),
		.core_select (req.core_select),
		.word_index  (req.word_index),
		.write_data  (req.write_data),
		.cmd         (dec_cmd)
	);

	idr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (dec_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	idr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.pop          (q_pop),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.read_data    (rsp.read_data),
		.access_error (rsp.access_error)
	);

endmodule

// ----- hw/rtl/idr_front.sv -----
// Front end: classifies one bus access and computes its storage addresses.
// Depends on idr_pkg.
`timescale 1ns / 1ps
module idr_front (
	input  logic         opcode,
	input  logic [2:0]   reg_kind,
	input  logic [1:0]   core_select,
	input  logic [6:0]   word_index,
	input  logic [31:0]  write_data,
	output idr_pkg::cmd_t cmd
);

	logic core_bad;
	logic priv_word;

	assign core_bad  = 32'(core_select) >= idr_pkg::NUM_CORES;
	assign priv_word = (word_index == 7'd0);

	// Range check per register kind
	always_comb begin
		cmd.wr        = opcode;
		cmd.kind      = idr_pkg::kind_t'(reg_kind);
		cmd.priv      = priv_word;
		cmd.core_idx  = idr_pkg::CORE_AW'(core_select);
		cmd.sh_idx    = idr_pkg::SW_AW'(word_index - 7'd1);
		cmd.route_idx = idr_pkg::ROUTE_AW'(32'(word_index) - idr_pkg::PRIVATE_INTERRUPTS);
		cmd.data      = write_data;
		if (32'(word_index) < idr_pkg::PRIV_PRIO_WORDS)
			cmd.prio_addr = idr_pkg::PRIO_AW'(32'(core_select) * idr_pkg::PRIV_PRIO_WORDS
				+ 32'(word_index));
		else
			cmd.prio_addr = idr_pkg::PRIO_AW'(idr_pkg::NUM_CORES * idr_pkg::PRIV_PRIO_WORDS
				+ 32'(word_index) - idr_pkg::PRIV_PRIO_WORDS);
		unique case (cmd.kind)
			idr_pkg::KIND_CONTROL:
				cmd.err = !priv_word;
			idr_pkg::KIND_SET_EN, idr_pkg::KIND_CLR_EN,
			idr_pkg::KIND_GROUP, idr_pkg::KIND_GROUP_MOD:
				cmd.err = priv_word ? core_bad : (32'(word_index) > idr_pkg::SHARED_WORDS);
			idr_pkg::KIND_PRIORITY:
				cmd.err = (32'(word_index) < idr_pkg::PRIV_PRIO_WORDS) ? core_bad
					: (32'(word_index) >= idr_pkg::PRIO_WORDS);
			idr_pkg::KIND_ROUTE:
				cmd.err = (32'(word_index) < idr_pkg::PRIVATE_INTERRUPTS)
					|| (32'(word_index) >= idr_pkg::NUM_INTERRUPTS);
			idr_pkg::KIND_WAKE:
				cmd.err = !priv_word || core_bad;
			default:
				cmd.err = 1'b1;
		endcase
	end

endmodule

// ----- hw/rtl/idr_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on idr_pkg.
`timescale 1ns / 1ps
module idr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  idr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output idr_pkg::cmd_t head
);

	idr_pkg::cmd_t entry_q [idr_pkg::Q_DEPTH];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    count_q;

	assign full      = (count_q == 2'(idr_pkg::Q_DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(idr_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

// ----- hw/rtl/idr_back.sv -----
// Back end: holds all registers, carries out accesses, drives the result.
// Depends on idr_pkg.
`timescale 1ns / 1ps
module idr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  idr_pkg::cmd_t cmd,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic [31:0]   read_data,
	output logic          access_error
);

	logic [idr_pkg::CTRL_W-1:0] ctrl_q;
	logic [31:0] priv_en_q  [idr_pkg::NUM_CORES];
	logic [31:0] priv_grp_q [idr_pkg::NUM_CORES];
	logic [31:0] priv_mod_q [idr_pkg::NUM_CORES];
	logic [31:0] sh_en_q    [idr_pkg::SHARED_WORDS];
	logic [31:0] sh_grp_q   [idr_pkg::SHARED_WORDS];
	logic [31:0] sh_mod_q   [idr_pkg::SHARED_WORDS];
	logic [idr_pkg::NUM_CORES-1:0] wake_q;

	logic [31:0] prio_mem [idr_pkg::PRIO_MEM_WORDS];
	logic [idr_pkg::PRIO_MEM_WORDS-1:0] prio_vld_q;
	logic [idr_pkg::ROUTE_W-1:0] route_mem [idr_pkg::SHARED_INTS];
	logic [idr_pkg::SHARED_INTS-1:0] route_vld_q;

	logic                        res_vld_q;
	logic                        res_err_q;
	idr_pkg::rd_sel_t            res_sel_q;
	logic [31:0]                 flop_rd_q;
	logic [31:0]                 prio_rd_q;
	logic                        prio_rdv_q;
	logic [idr_pkg::ROUTE_W-1:0] route_rd_q;
	logic                        route_rdv_q;

	logic        do_wr;
	logic [31:0] word_rd;
	logic [31:0] word_new;
	logic [idr_pkg::ROUTE_W-1:0] route_f;
	idr_pkg::rd_sel_t sel_d;

	assign pop   = cmd_valid && (!res_vld_q || rsp_ready);
	assign do_wr = pop && cmd.wr && !cmd.err;
	assign route_f = {cmd.data[31], cmd.data[9:8], cmd.data[1:0]};

	// Current contents of the addressed flop word
	always_comb begin
		word_rd = 32'd0;
		unique case (cmd.kind)
			idr_pkg::KIND_CONTROL:
				word_rd = 32'(ctrl_q);
			idr_pkg::KIND_SET_EN, idr_pkg::KIND_CLR_EN:
				word_rd = cmd.priv ? priv_en_q[cmd.core_idx] : sh_en_q[cmd.sh_idx];
			idr_pkg::KIND_GROUP:
				word_rd = cmd.priv ? priv_grp_q[cmd.core_idx] : sh_grp_q[cmd.sh_idx];
			idr_pkg::KIND_GROUP_MOD:
				word_rd = cmd.priv ? priv_mod_q[cmd.core_idx] : sh_mod_q[cmd.sh_idx];
			idr_pkg::KIND_WAKE:
				word_rd = {29'd0, wake_q[cmd.core_idx], wake_q[cmd.core_idx], 1'b0};
			default:
				word_rd = 32'd0;
		endcase
	end

	// Updated bit-array word
	always_comb begin
		unique case (cmd.kind)
			idr_pkg::KIND_SET_EN: word_new = word_rd | cmd.data;
			idr_pkg::KIND_CLR_EN: word_new = word_rd & ~cmd.data;
			default:              word_new = cmd.data;
		endcase
	end

	// Result source select
	always_comb begin
		if (cmd.wr || cmd.err)
			sel_d = idr_pkg::SEL_ZERO;
		else if (cmd.kind == idr_pkg::KIND_PRIORITY)
			sel_d = idr_pkg::SEL_PRIO;
		else if (cmd.kind == idr_pkg::KIND_ROUTE)
			sel_d = idr_pkg::SEL_ROUTE;
		else
			sel_d = idr_pkg::SEL_FLOP;
	end

	// Flop register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			wake_q      <= '0;
			prio_vld_q  <= '0;
			route_vld_q <= '0;
			for (int i = 0; i < idr_pkg::NUM_CORES; i++) begin
				priv_en_q[i]  <= '0;
				priv_grp_q[i] <= '0;
				priv_mod_q[i] <= '0;
			end
			for (int i = 0; i < idr_pkg::SHARED_WORDS; i++) begin
				sh_en_q[i]  <= '0;
				sh_grp_q[i] <= '0;
				sh_mod_q[i] <= '0;
			end
		end else if (do_wr) begin
			unique case (cmd.kind)
				idr_pkg::KIND_CONTROL:
					ctrl_q <= cmd.data[idr_pkg::CTRL_W-1:0];
				idr_pkg::KIND_SET_EN, idr_pkg::KIND_CLR_EN:
					if (cmd.priv)
						priv_en_q[cmd.core_idx] <= word_new;
					else
						sh_en_q[cmd.sh_idx] <= word_new;
				idr_pkg::KIND_GROUP:
					if (cmd.priv)
						priv_grp_q[cmd.core_idx] <= word_new;
					else
						sh_grp_q[cmd.sh_idx] <= word_new;
				idr_pkg::KIND_GROUP_MOD:
					if (cmd.priv)
						priv_mod_q[cmd.core_idx] <= word_new;
					else
						sh_mod_q[cmd.sh_idx] <= word_new;
				idr_pkg::KIND_PRIORITY:
					prio_vld_q[cmd.prio_addr] <= 1'b1;
				idr_pkg::KIND_ROUTE:
					route_vld_q[cmd.route_idx] <= 1'b1;
				idr_pkg::KIND_WAKE:
					wake_q[cmd.core_idx] <= cmd.data[1];
				default: ;
			endcase
		end
	end

	// Priority and route memories, registered read
	always_ff @(posedge clk) begin
		if (pop) begin
			if (do_wr && cmd.kind == idr_pkg::KIND_PRIORITY)
				prio_mem[cmd.prio_addr] <= cmd.data;
			if (do_wr && cmd.kind == idr_pkg::KIND_ROUTE)
				route_mem[cmd.route_idx] <= route_f;
			prio_rd_q  <= prio_mem[cmd.prio_addr];
			route_rd_q <= route_mem[cmd.route_idx];
			flop_rd_q  <= word_rd;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q   <= 1'b0;
			res_err_q   <= 1'b0;
			res_sel_q   <= idr_pkg::SEL_ZERO;
			prio_rdv_q  <= 1'b0;
			route_rdv_q <= 1'b0;
		end else if (pop) begin
			res_vld_q   <= 1'b1;
			res_err_q   <= cmd.err;
			res_sel_q   <= sel_d;
			prio_rdv_q  <= prio_vld_q[cmd.prio_addr];
			route_rdv_q <= route_vld_q[cmd.route_idx];
		end else if (rsp_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign rsp_valid    = res_vld_q;
	assign access_error = res_err_q;

	always_comb begin
		unique case (res_sel_q)
			idr_pkg::SEL_FLOP:  read_data = flop_rd_q;
			idr_pkg::SEL_PRIO:  read_data = prio_rdv_q ? prio_rd_q : 32'd0;
			idr_pkg::SEL_ROUTE: read_data = route_rdv_q
				? {route_rd_q[4], 21'd0, route_rd_q[3:2], 6'd0, route_rd_q[1:0]} : 32'd0;
			default:            read_data = 32'd0;
		endcase
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && access_error |-> read_data == 32'd0) else $error("error with data");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rsp_valid) else $error("popped access gave no result");
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd.wr |=> read_data == 32'd0) else $error("write returned data");

endmodule

// ----- tb/interrupt_distributor_registers_core_test.sv -----
// Self-checking testbench for the interrupt distributor register file.
// Predicts every register access and checks each response in order.
// Depends on idr_pkg, idr_if and interrupt_distributor_registers_core.
`timescale 1ns / 1ps
module interrupt_distributor_registers_core_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam bit OP_READ = 1'b0;
	localparam bit OP_WRITE = 1'b1;

	typedef struct {
		logic [31:0] read_data;
		logic        access_error;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	idr_req_if req ();
	idr_rsp_if rsp ();

	interrupt_distributor_registers_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the register state
	logic [6:0]  ctrl_shadow;
	logic [31:0] shared_en_shadow [idr_pkg::SHARED_WORDS];
	logic [31:0] private_en_shadow [idr_pkg::NUM_CORES];
	logic [31:0] shared_grp_shadow [idr_pkg::SHARED_WORDS];
	logic [31:0] private_grp_shadow [idr_pkg::NUM_CORES];
	logic [31:0] grp_mod_shadow [idr_pkg::NUM_CORES + idr_pkg::SHARED_WORDS];
	logic [7:0]  prio_shadow [idr_pkg::NUM_CORES * idr_pkg::PRIVATE_INTERRUPTS
		+ idr_pkg::SHARED_INTS];
	logic [4:0]  route_shadow [idr_pkg::SHARED_INTS];
	logic        sleep_shadow [idr_pkg::NUM_CORES];

	response_t expected_responses [$];
	int error_count = 0;
	int response_count = 0;
	int access_count = 0;
	int idle_cycles = 0;
	bit rsp_hold = 1'b0;

	// Apply one access to the shadow state and return its response
	function automatic response_t predict_access(bit wr, idr_pkg::kind_t kind, int core,
			int w, logic [31:0] data);
		response_t r;
		int base;
		logic [4:0] f;
		r.read_data = '0;
		r.access_error = 1'b0;
		case (kind)
			idr_pkg::KIND_CONTROL: begin
				if (w != 0) r.access_error = 1'b1;
				else if (wr) ctrl_shadow = data[6:0];
				else r.read_data = {25'd0, ctrl_shadow};
			end
			idr_pkg::KIND_SET_EN, idr_pkg::KIND_CLR_EN, idr_pkg::KIND_GROUP,
			idr_pkg::KIND_GROUP_MOD: begin
				if ((w == 0 && core >= idr_pkg::NUM_CORES) || w > idr_pkg::SHARED_WORDS) begin
					r.access_error = 1'b1;
				end else begin
					logic [31:0] cur;
					if (kind == idr_pkg::KIND_GROUP) cur = (w == 0) ? private_grp_shadow[core]
						: shared_grp_shadow[w-1];
					else if (kind == idr_pkg::KIND_GROUP_MOD) cur = (w == 0)
						? grp_mod_shadow[core] : grp_mod_shadow[idr_pkg::NUM_CORES+w-1];
					else cur = (w == 0) ? private_en_shadow[core] : shared_en_shadow[w-1];
					if (!wr) r.read_data = cur;
					else begin
						if (kind == idr_pkg::KIND_SET_EN) cur = cur | data;
						else if (kind == idr_pkg::KIND_CLR_EN) cur = cur & ~data;
						else cur = data;
						if (kind == idr_pkg::KIND_GROUP) begin
							if (w == 0) private_grp_shadow[core] = cur;
							else shared_grp_shadow[w-1] = cur;
						end else if (kind == idr_pkg::KIND_GROUP_MOD) begin
							if (w == 0) grp_mod_shadow[core] = cur;
							else grp_mod_shadow[idr_pkg::NUM_CORES+w-1] = cur;
						end else begin
							if (w == 0) private_en_shadow[core] = cur;
							else shared_en_shadow[w-1] = cur;
						end
					end
				end
			end
			idr_pkg::KIND_PRIORITY: begin
				if ((w < idr_pkg::PRIV_PRIO_WORDS && core >= idr_pkg::NUM_CORES)
						|| w >= idr_pkg::PRIO_WORDS) begin
					r.access_error = 1'b1;
				end else begin
					base = (w < idr_pkg::PRIV_PRIO_WORDS)
						? core * idr_pkg::PRIVATE_INTERRUPTS + w * 4
						: idr_pkg::NUM_CORES * idr_pkg::PRIVATE_INTERRUPTS + w * 4
							- idr_pkg::PRIVATE_INTERRUPTS;
					for (int k = 0; k < 4; k++) begin
						if (wr) prio_shadow[base+k] = data[8*k +: 8];
						else r.read_data[8*k +: 8] = prio_shadow[base+k];
					end
				end
			end
			idr_pkg::KIND_ROUTE: begin
				if (w < idr_pkg::PRIVATE_INTERRUPTS || w >= idr_pkg::NUM_INTERRUPTS) begin
					r.access_error = 1'b1;
				end else if (wr) begin
					route_shadow[w-idr_pkg::PRIVATE_INTERRUPTS] =
						{data[31], data[9:8], data[1:0]};
				end else begin
					f = route_shadow[w-idr_pkg::PRIVATE_INTERRUPTS];
					r.read_data = {f[4], 21'd0, f[3:2], 6'd0, f[1:0]};
				end
			end
			default: begin
				if (w != 0 || core >= idr_pkg::NUM_CORES) r.access_error = 1'b1;
				else if (wr) sleep_shadow[core] = data[1];
				else r.read_data = {29'd0, sleep_shadow[core], sleep_shadow[core], 1'b0};
			end
		endcase
		if (wr || r.access_error) r.read_data = '0;
		return r;
	endfunction

	// Send one access after a random gap and record its expected response;
	// valid stays high when the next access follows with no gap
	task automatic send_access(bit wr, idr_pkg::kind_t kind, int core, int w,
			logic [31:0] data);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= wr;
		req.reg_kind <= kind;
		req.core_select <= core[1:0];
		req.word_index <= w[6:0];
		req.write_data <= data;
		do @(posedge clk); while (!req.ready);
		expected_responses.push_back(predict_access(wr, kind, core, w, data));
		access_count++;
	endtask

	// Response acceptor: draws a random wait for every transfer
	initial begin
		int wait_left;
		rsp.ready = 1'b0;
		wait_left = $urandom_range(0, 3);
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_hold) begin
				rsp.ready <= 1'b0;
			end else if (rsp.ready && rsp.valid) begin
				wait_left = $urandom_range(0, 3);
				if (wait_left == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					wait_left--;
				end
			end else if (wait_left > 0) begin
				rsp.ready <= 1'b0;
				wait_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Response checker: samples transfers at the clock edge
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			response_t exp_r;
			response_count++;
			if (expected_responses.size() == 0) begin
				$error("response with nothing expected: read_data=%h access_error=%b",
					rsp.read_data, rsp.access_error);
				error_count++;
			end else begin
				exp_r = expected_responses.pop_front();
				if (rsp.read_data !== exp_r.read_data) begin
					$error("read_data expected %h actual %h", exp_r.read_data, rsp.read_data);
					error_count++;
				end
				if (rsp.access_error !== exp_r.access_error) begin
					$error("access_error expected %b actual %b", exp_r.access_error,
						rsp.access_error);
					error_count++;
				end
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Random index that lands mostly in range for the kind
	function automatic int pick_index(idr_pkg::kind_t kind);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
		case (kind)
			idr_pkg::KIND_CONTROL, idr_pkg::KIND_WAKE: return 0;
			idr_pkg::KIND_PRIORITY: return $urandom_range(0, idr_pkg::PRIO_WORDS - 1);
			idr_pkg::KIND_ROUTE: return $urandom_range(idr_pkg::PRIVATE_INTERRUPTS,
				idr_pkg::NUM_INTERRUPTS - 1);
			default: return $urandom_range(0, idr_pkg::SHARED_WORDS);
		endcase
	endfunction

	task automatic test_directed();
		send_access(OP_WRITE, idr_pkg::KIND_CONTROL, 0, 0, 32'hFFFF_FFFF);
		send_access(OP_READ, idr_pkg::KIND_CONTROL, 0, 0, 32'h0);
		send_access(OP_READ, idr_pkg::KIND_CONTROL, 0, 1, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_SET_EN, 3, 0, 32'hA5A5_0001);
		send_access(OP_WRITE, idr_pkg::KIND_CLR_EN, 3, 0, 32'h0000_0F01);
		send_access(OP_READ, idr_pkg::KIND_SET_EN, 3, 0, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_SET_EN, 0, idr_pkg::SHARED_WORDS, 32'hFFFF_FFFF);
		send_access(OP_READ, idr_pkg::KIND_CLR_EN, 0, idr_pkg::SHARED_WORDS, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_GROUP, 1, idr_pkg::SHARED_WORDS + 1,
			32'h1234_5678);
		send_access(OP_WRITE, idr_pkg::KIND_GROUP, 2, 0, 32'h8000_0001);
		send_access(OP_READ, idr_pkg::KIND_GROUP, 2, 0, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_GROUP_MOD, 0, 1, 32'hDEAD_BEEF);
		send_access(OP_READ, idr_pkg::KIND_GROUP_MOD, 0, 1, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_PRIORITY, 2, 0, 32'h0102_03FF);
		send_access(OP_READ, idr_pkg::KIND_PRIORITY, 2, 0, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_PRIORITY, 0, idr_pkg::PRIO_WORDS - 1,
			32'hFF00_80C0);
		send_access(OP_READ, idr_pkg::KIND_PRIORITY, 3, idr_pkg::PRIO_WORDS - 1, 32'h0);
		send_access(OP_READ, idr_pkg::KIND_PRIORITY, 0, 127, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_ROUTE, 0, idr_pkg::NUM_INTERRUPTS - 1,
			32'hFFFF_FFFF);
		send_access(OP_READ, idr_pkg::KIND_ROUTE, 0, idr_pkg::NUM_INTERRUPTS - 1, 32'h0);
		send_access(OP_READ, idr_pkg::KIND_ROUTE, 0, idr_pkg::PRIVATE_INTERRUPTS - 1, 32'h0);
		send_access(OP_WRITE, idr_pkg::KIND_WAKE, 1, 0, 32'h0000_0002);
		send_access(OP_READ, idr_pkg::KIND_WAKE, 1, 0, 32'h0);
		send_access(OP_READ, idr_pkg::KIND_WAKE, 1, 1, 32'h0);
	endtask

	task automatic test_random(int count);
		idr_pkg::kind_t kind;
		for (int i = 0; i < count; i++) begin
			kind = idr_pkg::kind_t'($urandom_range(0, 7));
			send_access($urandom_range(0, 1), kind, $urandom_range(0, 3), pick_index(kind),
				$urandom());
		end
	endtask

	// Receiver holds off long enough for the queue to fill and stall requests
	task automatic test_backpressure();
		fork
			begin
				rsp_hold = 1'b1;
				repeat (40) @(posedge clk);
				rsp_hold = 1'b0;
			end
			test_random(20);
		join
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = 1'b0;
		req.reg_kind = idr_pkg::KIND_CONTROL;
		req.core_select = '0;
		req.word_index = '0;
		req.write_data = '0;
		ctrl_shadow = '0;
		foreach (shared_en_shadow[i]) shared_en_shadow[i] = '0;
		foreach (private_en_shadow[i]) private_en_shadow[i] = '0;
		foreach (shared_grp_shadow[i]) shared_grp_shadow[i] = '0;
		foreach (private_grp_shadow[i]) private_grp_shadow[i] = '0;
		foreach (grp_mod_shadow[i]) grp_mod_shadow[i] = '0;
		foreach (prio_shadow[i]) prio_shadow[i] = '0;
		foreach (route_shadow[i]) route_shadow[i] = '0;
		foreach (sleep_shadow[i]) sleep_shadow[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(760);
		req.valid <= 1'b0;

		while (expected_responses.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		$display("Covered %0d accesses of every register kind, in and out of range,",
			access_count);
		$display("with random gaps and one long response stall; %0d responses checked.",
			response_count);
		if (error_count == 0 && expected_responses.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
